>>> rtl/svie_pkg.sv
// svie_pkg: opcodes, error codes, controller states and saturation helper
// for the stack machine execution core; no dependencies
`default_nettype none

package svie_pkg;

	localparam logic [4:0] OP_PUSH_C = 5'd1;
	localparam logic [4:0] OP_PUSH_R = 5'd2;
	localparam logic [4:0] OP_POP    = 5'd3;
	localparam logic [4:0] OP_POP_R  = 5'd4;
	localparam logic [4:0] OP_IN     = 5'd5;
	localparam logic [4:0] OP_OUT    = 5'd6;
	localparam logic [4:0] OP_ADD    = 5'd7;
	localparam logic [4:0] OP_ADD_R  = 5'd8;
	localparam logic [4:0] OP_SUB    = 5'd9;
	localparam logic [4:0] OP_SUB_R  = 5'd10;
	localparam logic [4:0] OP_MUL    = 5'd11;
	localparam logic [4:0] OP_MUL_R  = 5'd12;
	localparam logic [4:0] OP_DIV    = 5'd13;
	localparam logic [4:0] OP_DIV_R  = 5'd14;
	localparam logic [4:0] OP_INC    = 5'd15;
	localparam logic [4:0] OP_DEC    = 5'd16;
	localparam logic [4:0] OP_MOV_C  = 5'd17;
	localparam logic [4:0] OP_MOV_R  = 5'd18;
	localparam logic [4:0] OP_LABEL  = 5'd19;
	localparam logic [4:0] OP_JMP    = 5'd20;
	localparam logic [4:0] OP_JE     = 5'd21;
	localparam logic [4:0] OP_JNE    = 5'd22;
	localparam logic [4:0] OP_JL     = 5'd23;
	localparam logic [4:0] OP_JG     = 5'd24;
	localparam logic [4:0] OP_CALL   = 5'd25;
	localparam logic [4:0] OP_RET    = 5'd26;
	localparam logic [4:0] OP_END    = 5'd27;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_OP    = 3'd1;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [2:0] ERR_CALL      = 3'd4;
	localparam logic [2:0] ERR_DIV_ZERO  = 3'd5;
	localparam logic [2:0] ERR_BAD_REG   = 3'd6;

	localparam logic [31:0] Q_ONE   = 32'h0001_0000;
	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD2,
		ST_RD3,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_WB
	} state_t;

	// clamp a 33-bit signed sum to 32 bits
	function automatic logic [31:0] sat33(input logic [32:0] s);
		logic [31:0] r;
		if (s[32] != s[31]) begin
			r = s[32] ? SAT_MIN : SAT_MAX;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/svie_ram.sv
// svie_ram: generic single-write, single-read synchronous RAM with registered read
// no dependencies
`default_nettype none

module svie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/svie_div.sv
// svie_div: Q16.16 saturating divider, restoring, one quotient bit per cycle
// depends on svie_pkg
`default_nettype none

module svie_div import svie_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic [47:0] sh_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [31:0] mag_a;
	logic [31:0] mag_b;
	logic [32:0] trial;
	logic        fits;

	assign mag_a = dividend[31] ? (32'd0 - dividend) : dividend;
	assign mag_b = divisor[31] ? (32'd0 - divisor) : divisor;
	assign trial = {rem_q, sh_q[47]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= {mag_a, 16'd0};
			rem_q <= '0;
			den_q <= mag_b;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			sh_q  <= {sh_q[46:0], fits};
		end
	end

	always_comb begin
		if (!neg_q) begin
			quotient = (|sh_q[47:31]) ? SAT_MAX : sh_q[31:0];
		end else if ((|sh_q[47:32]) || (sh_q[31] && (|sh_q[30:0]))) begin
			quotient = SAT_MIN;
		end else begin
			quotient = 32'd0 - sh_q[31:0];
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

>>> rtl/stack_vm_instruction_execute.sv
// stack_vm_instruction_execute: top level of the stack machine execution core
// depends on svie_pkg, svie_ram (register file, data stack, return stack), svie_div
`default_nettype none

// Executes one fetched instruction per transaction and returns one result with
// the next fetch address, an optional output value, halt and an error code.
// Registers, data stack and return stack live in synchronous RAMs; each
// instruction reads them in ST_RD2 and ST_RD3, decides in ST_EXEC and writes
// back in ST_WB, which waits until the previous result has been taken.
// Multiplies pass through ST_MUL for the registered product; divides wait in
// ST_DIV for the bit-serial divider. One instruction is in flight at a time;
// a result waits in the output register while the next instruction is
// accepted. PROG_WORDS must be a power of two. Values are Q16.16 and all
// arithmetic saturates to 32 bits.
module stack_vm_instruction_execute import svie_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int CALL_DEPTH  = 16,
	parameter int PROG_WORDS  = 4096,
	parameter int NUM_REGS    = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [12:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [4:0]         mode,
	input  wire logic [2:0]         reg_a,
	input  wire logic [2:0]         reg_b,
	input  wire logic [2:0]         reg_c,
	input  wire logic signed [31:0] immediate,
	input  wire logic [11:0]        jump_target,
	input  wire logic signed [31:0] in_value,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic [11:0]             next_pc,
	output logic                    out_valid,
	output logic signed [31:0]      out_value,
	output logic                    halted,
	output logic [2:0]              error_code
);

	localparam int DAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
	localparam int DCW = $clog2(STACK_DEPTH + 1);
	localparam int CCW = $clog2(CALL_DEPTH + 1);
	localparam int PCW = $clog2(PROG_WORDS);
	localparam int RAW = $clog2(NUM_REGS);

	state_t state_q, state_d;

	logic [12:0]     plen_q;
	logic [DCW-1:0]  ds_cnt_q;
	logic [CCW-1:0]  rs_cnt_q;
	logic [PCW-1:0]  pc_q;
	logic            stopped_q;
	logic [7:0]      reg_vld_q;

	// latched instruction
	logic [4:0]        mode_q;
	logic [2:0]        ra_q, rb_q, rc_q;
	logic [31:0]       imm_q, inv_q;
	logic [11:0]       tgt_q;
	logic              rreg_q;

	// operands gathered from the RAMs
	logic signed [31:0] regx_q, regy_q, top_q, nxt_q;
	logic [PCW-1:0]     rtop_q;

	// decision made in the execute cycle
	logic [2:0]      err_q;
	logic            outv_q;
	logic [31:0]     val_q;
	logic            ds_we_q, reg_we_q, rs_we_q;
	logic [DAW-1:0]  ds_wa_q;
	logic [DCW-1:0]  ds_cnt_nxt_q;
	logic [CCW-1:0]  rs_cnt_nxt_q;
	logic [PCW-1:0]  pc_nxt_q;
	logic            stop_nxt_q;
	logic            mul_q, div_q;
	logic signed [63:0] prod_s1;

	// RAM ports
	logic [RAW-1:0]  reg_raddr;
	logic [31:0]     reg_rdata;
	logic [DAW-1:0]  ds_raddr;
	logic [31:0]     ds_rdata;
	logic [CAW-1:0]  rs_raddr;
	logic [PCW-1:0]  rs_rdata;
	logic [PCW-1:0]  rs_wdata;

	logic            in_xfer, wb_go, div_start, div_done;
	logic [31:0]     div_quot;
	logic            rreg_in;
	logic [2:0]      xa, ya;
	logic [DCW-1:0]  ds_m1, ds_m2;
	logic [CCW-1:0]  rs_m1;
	logic [16:0]     len17, pc17, raw17, tgt17, pcx;
	logic            at_end;

	// execute-cycle combinational decision
	logic [2:0]      e_err;
	logic            e_outv, e_ds_we, e_reg_we, e_rs_we, e_jump, e_end, e_mul, e_div;
	logic [31:0]     e_val;
	logic [DAW-1:0]  e_ds_wa;
	logic [DCW-1:0]  e_ds_cnt;
	logic [CCW-1:0]  e_rs_cnt;
	logic [16:0]     e_tgt, e_raw;
	logic [PCW-1:0]  e_pc;
	logic            e_stop;
	logic [1:0]      nregs;
	logic            bad_reg;
	logic signed [31:0] op_a, op_b;
	logic [31:0]     mul_sat;
	logic [47:0]     mul_q48;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign wb_go     = (state_q == ST_WB) && (!res_valid || res_ready);
	assign rreg_in   = mode inside {OP_ADD_R, OP_SUB_R, OP_MUL_R, OP_DIV_R};

	assign ds_m1 = ds_cnt_q - DCW'(1);
	assign ds_m2 = ds_cnt_q - DCW'(2);
	assign rs_m1 = rs_cnt_q - CCW'(1);

	assign len17  = (17'(plen_q) > 17'(PROG_WORDS)) ? 17'(PROG_WORDS) : 17'(plen_q);
	assign pc17   = 17'(pc_q);
	assign raw17  = pc17 + 17'd5;
	// jump targets wrap at PROG_WORDS
	assign tgt17  = 17'(tgt_q) & 17'(PROG_WORDS - 1);
	assign at_end = pc17 >= len17;

	// RAM read addresses: first operands on accept, second ones in ST_RD2
	always_comb begin
		if (state_q == ST_RD2) begin
			reg_raddr = RAW'(rreg_q ? rc_q : rb_q);
			ds_raddr  = ds_m2[DAW-1:0];
		end else begin
			reg_raddr = RAW'(rreg_in ? reg_b : reg_a);
			ds_raddr  = ds_m1[DAW-1:0];
		end
		rs_raddr = rs_m1[CAW-1:0];
	end

	assign xa = rreg_q ? rb_q : ra_q;
	assign ya = rreg_q ? rc_q : rb_q;
	assign rs_wdata = raw17[PCW-1:0];

	svie_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_regs (
		.clk   (clk),
		.we    (wb_go && reg_we_q),
		.waddr (RAW'(ra_q)),
		.wdata (val_q),
		.raddr (reg_raddr),
		.rdata (reg_rdata)
	);

	svie_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_dstack (
		.clk   (clk),
		.we    (wb_go && ds_we_q),
		.waddr (ds_wa_q),
		.wdata (val_q),
		.raddr (ds_raddr),
		.rdata (ds_rdata)
	);

	svie_ram #(.WIDTH(PCW), .DEPTH(CALL_DEPTH)) u_rstack (
		.clk   (clk),
		.we    (wb_go && rs_we_q),
		.waddr (rs_cnt_q[CAW-1:0]),
		.wdata (rs_wdata),
		.raddr (rs_raddr),
		.rdata (rs_rdata)
	);

	svie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (op_a),
		.divisor  (op_b),
		.done     (div_done),
		.quotient (div_quot)
	);

	// operand selection for the arithmetic ops
	always_comb begin
		if (mode_q inside {OP_ADD_R, OP_SUB_R, OP_MUL_R, OP_DIV_R}) begin
			op_a = regx_q;
			op_b = regy_q;
		end else begin
			op_a = nxt_q;
			op_b = top_q;
		end
	end

	always_comb begin
		if (mode_q inside {OP_PUSH_R, OP_POP, OP_POP_R, [OP_INC:OP_MOV_C], OP_JE, OP_JNE}) begin
			nregs = 2'd1;
		end else if (mode_q inside {OP_MOV_R, OP_JL, OP_JG}) begin
			nregs = 2'd2;
		end else if (rreg_q) begin
			nregs = 2'd3;
		end else begin
			nregs = 2'd0;
		end
		bad_reg = (nregs >= 2'd1 && 32'(ra_q) >= NUM_REGS) ||
			(nregs >= 2'd2 && 32'(rb_q) >= NUM_REGS) ||
			(nregs == 2'd3 && 32'(rc_q) >= NUM_REGS);
	end

	// decide the effect of the instruction
	always_comb begin
		e_err    = ERR_NONE;
		e_outv   = 1'b0;
		e_val    = '0;
		e_ds_we  = 1'b0;
		e_ds_wa  = ds_cnt_q[DAW-1:0];
		e_ds_cnt = ds_cnt_q;
		e_reg_we = 1'b0;
		e_rs_we  = 1'b0;
		e_rs_cnt = rs_cnt_q;
		e_jump   = 1'b0;
		e_tgt    = tgt17;
		e_end    = 1'b0;
		e_mul    = 1'b0;
		e_div    = 1'b0;
		if (stopped_q || at_end) begin
			e_end = 1'b1;
		end else if (bad_reg) begin
			e_err = ERR_BAD_REG;
		end else begin
			case (mode_q)
				OP_PUSH_C, OP_PUSH_R, OP_IN: begin
					if (32'(ds_cnt_q) >= STACK_DEPTH) begin
						e_err = ERR_OVERFLOW;
					end else begin
						e_ds_we  = 1'b1;
						e_ds_cnt = ds_cnt_q + DCW'(1);
						e_val    = (mode_q == OP_PUSH_C) ? imm_q :
							(mode_q == OP_PUSH_R) ? regx_q : inv_q;
					end
				end
				OP_POP, OP_POP_R: begin
					if (ds_cnt_q == '0) begin
						e_err = ERR_UNDERFLOW;
					end else begin
						e_ds_cnt = ds_m1;
						e_reg_we = (mode_q == OP_POP_R);
						e_val    = top_q;
					end
				end
				OP_OUT: begin
					if (ds_cnt_q == '0) begin
						e_err = ERR_UNDERFLOW;
					end else begin
						e_outv = 1'b1;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (ds_cnt_q < DCW'(2)) begin
						e_err = ERR_UNDERFLOW;
					end else if (mode_q == OP_DIV && top_q == 0) begin
						e_err = ERR_DIV_ZERO;
					end else begin
						e_ds_we  = 1'b1;
						e_ds_wa  = ds_m2[DAW-1:0];
						e_ds_cnt = ds_m1;
						e_mul    = (mode_q == OP_MUL);
						e_div    = (mode_q == OP_DIV);
						e_val    = (mode_q == OP_ADD) ?
							sat33({op_a[31], op_a} + {op_b[31], op_b}) :
							sat33({op_a[31], op_a} - {op_b[31], op_b});
					end
				end
				OP_ADD_R, OP_SUB_R, OP_MUL_R, OP_DIV_R: begin
					if (mode_q == OP_DIV_R && regy_q == 0) begin
						e_err = ERR_DIV_ZERO;
					end else begin
						e_reg_we = 1'b1;
						e_mul    = (mode_q == OP_MUL_R);
						e_div    = (mode_q == OP_DIV_R);
						e_val    = (mode_q == OP_ADD_R) ?
							sat33({op_a[31], op_a} + {op_b[31], op_b}) :
							sat33({op_a[31], op_a} - {op_b[31], op_b});
					end
				end
				OP_INC: begin
					e_reg_we = 1'b1;
					e_val    = sat33({regx_q[31], regx_q} + {1'b0, Q_ONE});
				end
				OP_DEC: begin
					e_reg_we = 1'b1;
					e_val    = sat33({regx_q[31], regx_q} - {1'b0, Q_ONE});
				end
				OP_MOV_C: begin
					e_reg_we = 1'b1;
					e_val    = imm_q;
				end
				OP_MOV_R: begin
					e_reg_we = 1'b1;
					e_val    = regy_q;
				end
				OP_JMP: e_jump = 1'b1;
				OP_JE:  e_jump = (regx_q == 0);
				OP_JNE: e_jump = (regx_q != 0);
				OP_JL:  e_jump = (regx_q < regy_q);
				OP_JG:  e_jump = (regx_q > regy_q);
				OP_CALL: begin
					if (32'(rs_cnt_q) >= CALL_DEPTH) begin
						e_err = ERR_CALL;
					end else begin
						e_rs_we  = 1'b1;
						e_rs_cnt = rs_cnt_q + CCW'(1);
						e_jump   = 1'b1;
					end
				end
				OP_RET: begin
					if (rs_cnt_q == '0) begin
						e_err = ERR_CALL;
					end else begin
						e_rs_cnt = rs_m1;
						e_tgt    = 17'(rtop_q);
						e_jump   = 1'b1;
					end
				end
				OP_END: e_end = 1'b1;
				default: e_err = ERR_BAD_OP;
			endcase
		end
		e_raw = e_jump ? e_tgt : raw17;
		if (e_end) begin
			e_pc   = pc_q;
			e_stop = 1'b1;
		end else begin
			e_pc   = e_raw[PCW-1:0];
			e_stop = e_raw >= len17;
		end
	end

	assign div_start = (state_q == ST_EXEC) && e_div;

	// product is floor-shifted by 16, then clamped
	assign mul_q48 = prod_s1[63:16];
	always_comb begin
		if ((mul_q48[47:31] != '0) && (mul_q48[47:31] != '1)) begin
			mul_sat = mul_q48[47] ? SAT_MIN : SAT_MAX;
		end else begin
			mul_sat = mul_q48[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_RD2;
			ST_RD2:  state_d = ST_RD3;
			ST_RD3:  state_d = ST_EXEC;
			ST_EXEC: begin
				if (e_mul) begin
					state_d = ST_MUL;
				end else if (e_div) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_WB;
				end
			end
			ST_MUL:  state_d = ST_WB;
			ST_DIV:  if (div_done) state_d = ST_WB;
			ST_WB:   if (wb_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			ds_cnt_q  <= '0;
			rs_cnt_q  <= '0;
			pc_q      <= '0;
			stopped_q <= 1'b0;
			reg_vld_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				plen_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			if (wb_go) begin
				ds_cnt_q  <= ds_cnt_nxt_q;
				rs_cnt_q  <= rs_cnt_nxt_q;
				pc_q      <= pc_nxt_q;
				stopped_q <= stop_nxt_q;
				res_valid <= 1'b1;
				if (reg_we_q) begin
					reg_vld_q[ra_q] <= 1'b1;
				end
			end
		end
	end

	assign pcx = 17'(pc_nxt_q);

	always_ff @(posedge clk) begin
		if (wb_go) begin
			next_pc    <= pcx[11:0];
			out_valid  <= outv_q;
			out_value  <= outv_q ? top_q : 32'sd0;
			halted     <= stop_nxt_q;
			error_code <= err_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= mode;
			ra_q   <= reg_a;
			rb_q   <= reg_b;
			rc_q   <= reg_c;
			imm_q  <= immediate;
			inv_q  <= in_value;
			tgt_q  <= jump_target;
			rreg_q <= rreg_in;
		end
		if (state_q == ST_RD2) begin
			regx_q <= reg_vld_q[xa] ? reg_rdata : 32'sd0;
			top_q  <= ds_rdata;
			rtop_q <= rs_rdata;
		end
		if (state_q == ST_RD3) begin
			regy_q <= reg_vld_q[ya] ? reg_rdata : 32'sd0;
			nxt_q  <= ds_rdata;
		end
		if (state_q == ST_EXEC) begin
			err_q        <= e_err;
			outv_q       <= e_outv;
			val_q        <= e_val;
			ds_we_q      <= e_ds_we;
			ds_wa_q      <= e_ds_wa;
			ds_cnt_nxt_q <= e_ds_cnt;
			reg_we_q     <= e_reg_we;
			rs_we_q      <= e_rs_we;
			rs_cnt_nxt_q <= e_rs_cnt;
			pc_nxt_q     <= e_pc;
			stop_nxt_q   <= e_stop;
			mul_q        <= e_mul;
			div_q        <= e_div;
			prod_s1      <= op_a * op_b;
		end
		if (state_q == ST_MUL) begin
			val_q <= mul_sat;
		end
		if (state_q == ST_DIV && div_done) begin
			val_q <= div_quot;
		end
	end

	// stack counts stay within their depths
	a_ds_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ds_cnt_q) <= STACK_DEPTH)
		else $error("data stack count beyond depth");

	a_rs_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rs_cnt_q) <= CALL_DEPTH)
		else $error("return stack count beyond depth");

	// a shown value never comes with an error
	a_out_err: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_valid) |-> (error_code == ERR_NONE))
		else $error("out value reported together with an error");

	// the divider finishes only while the controller waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV && div_q && !mul_q))
		else $error("divider done outside divide wait");

endmodule

`default_nettype wire

>>> tb/stack_vm_instruction_execute_tb.sv
// stack_vm_instruction_execute_tb: self-checking testbench for the stack machine execution core
// depends on svie_pkg and the stack_vm_instruction_execute rtl; directed table then random programs
`default_nettype none

module stack_vm_instruction_execute_tb;
	import svie_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned PHASE_ITEMS = 250;

	typedef struct packed {
		logic [4:0]  mode;
		logic [2:0]  ra;
		logic [2:0]  rb;
		logic [2:0]  rc;
		logic [31:0] imm;
		logic [11:0] tgt;
		logic [31:0] inval;
	} instr_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic        out_valid;
		logic [31:0] out_value;
		logic        halted;
		logic [2:0]  error_code;
	} outcome_t;

	// typed: 1 when next_pc and error are written in the row, else the predictor decides
	typedef struct packed {
		logic        typed;
		instr_t      ins;
		logic [11:0] epc;
		logic [2:0]  eerr;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [12:0] cfg_data;
	logic in_valid, in_ready;
	logic [4:0] mode;
	logic [2:0] reg_a, reg_b, reg_c;
	logic signed [31:0] immediate, in_value;
	logic [11:0] jump_target;
	logic res_valid, res_ready;
	logic [11:0] next_pc;
	logic out_valid;
	logic signed [31:0] out_value;
	logic halted;
	logic [2:0] error_code;

	// shadow machine state
	logic signed [31:0] vm_regs [0:4];
	logic signed [31:0] vm_dstack [0:15];
	int unsigned vm_dcount;
	logic [11:0] vm_rstack [0:15];
	int unsigned vm_rcount;
	int unsigned vm_pc;
	bit vm_stopped;
	int unsigned vm_len;

	outcome_t pending_q [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_reqs = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned n_items = 0, n_results = 0, n_outs = 0, n_errs = 0;

	dir_row_t dir_rows [0:25] = '{
		'{1'b1, '{OP_POP,   3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd5,  ERR_UNDERFLOW},
		'{1'b1, '{OP_OUT,   3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd10, ERR_UNDERFLOW},
		'{1'b1, '{OP_PUSH_R, 3'd7, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd15, ERR_BAD_REG},
		'{1'b1, '{5'd0,     3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd20, ERR_BAD_OP},
		'{1'b1, '{OP_LABEL, 3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd25, ERR_BAD_OP},
		'{1'b1, '{5'd31, 3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF},
			12'd30, ERR_BAD_OP},
		'{1'b0, '{OP_PUSH_C, 3'd0, 3'd0, 3'd0, SAT_MAX, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_PUSH_C, 3'd0, 3'd0, 3'd0, SAT_MAX, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_ADD,   3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_PUSH_C, 3'd0, 3'd0, 3'd0, SAT_MIN, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_MUL,   3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_PUSH_C, 3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b1, '{OP_DIV,   3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd65, ERR_DIV_ZERO},
		'{1'b0, '{OP_IN,    3'd0, 3'd0, 3'd0, 32'd0, 12'd0, SAT_MIN}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_MOV_C, 3'd4, 3'd0, 3'd0, SAT_MIN, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_DEC,   3'd4, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_MOV_C, 3'd0, 3'd0, 3'd0, 32'h0003_0000, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b1, '{OP_DIV_R, 3'd1, 3'd0, 3'd2, 32'd0, 12'd0, 32'd0}, 12'd90, ERR_DIV_ZERO},
		'{1'b0, '{OP_MUL_R, 3'd3, 3'd0, 3'd4, 32'd0, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_INC,   3'd3, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b1, '{OP_RET,   3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd105, ERR_CALL},
		'{1'b0, '{OP_CALL,  3'd0, 3'd0, 3'd0, 32'd0, 12'hFFF, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_RET,   3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_JL,    3'd4, 3'd0, 3'd0, 32'd0, 12'd500, 32'd0}, 12'd0, ERR_NONE},
		'{1'b1, '{OP_JMP,   3'd0, 3'd0, 3'd0, 32'd0, 12'd0, 32'd0}, 12'd0, ERR_NONE},
		'{1'b0, '{OP_JE,    3'd2, 3'd0, 3'd0, 32'd0, 12'd200, 32'd0}, 12'd0, ERR_NONE}
	};

	stack_vm_instruction_execute u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .reg_a(reg_a), .reg_b(reg_b), .reg_c(reg_c),
		.immediate(immediate), .jump_target(jump_target), .in_value(in_value),
		.res_valid(res_valid), .res_ready(res_ready),
		.next_pc(next_pc), .out_valid(out_valid), .out_value(out_value),
		.halted(halted), .error_code(error_code)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(input longint v);
		logic signed [31:0] r;
		if (v > 64'sh7FFF_FFFF) r = SAT_MAX;
		else if (v < -64'sh8000_0000) r = SAT_MIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp32(p >>> 16);
	endfunction

	function automatic logic signed [31:0] fx_div(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp32((longint'(a) * 64'sd65536) / longint'(b));
	endfunction

	function automatic logic signed [31:0] fx_arith(input logic [4:0] op,
			input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [31:0] r;
		case (op)
			OP_ADD, OP_ADD_R: r = clamp32(longint'(a) + longint'(b));
			OP_SUB, OP_SUB_R: r = clamp32(longint'(a) - longint'(b));
			OP_MUL, OP_MUL_R: r = fx_mul(a, b);
			default:          r = fx_div(a, b);
		endcase
		return r;
	endfunction

	// advances the shadow machine by one instruction and returns what the core must report
	function automatic outcome_t execute_instr(input instr_t it);
		outcome_t r;
		int unsigned lim, raw, tgt, nregs;
		bit jump;
		logic signed [31:0] a, b;
		logic [4:0] m;
		m = it.mode;
		r = '0;
		lim = (vm_len > 4096) ? 4096 : vm_len;
		raw = vm_pc + 5;
		tgt = it.tgt;
		nregs = 0;
		jump = 1'b0;
		if (!vm_stopped && vm_pc >= lim) vm_stopped = 1'b1;
		if (!vm_stopped) begin
			if ((m >= OP_PUSH_R && m <= OP_POP_R) || (m >= OP_INC && m <= OP_MOV_C) ||
					m == OP_JE || m == OP_JNE) nregs = 1;
			else if (m == OP_MOV_R || m == OP_JL || m == OP_JG) nregs = 2;
			else if (m == OP_ADD_R || m == OP_SUB_R || m == OP_MUL_R || m == OP_DIV_R) nregs = 3;
			if ((nregs >= 1 && it.ra > 4) || (nregs >= 2 && it.rb > 4) ||
					(nregs >= 3 && it.rc > 4)) begin
				r.error_code = ERR_BAD_REG;
			end else begin
				case (m)
					OP_PUSH_C, OP_PUSH_R, OP_IN: begin
						if (vm_dcount >= 16) r.error_code = ERR_OVERFLOW;
						else begin
							vm_dstack[vm_dcount] = (m == OP_PUSH_C) ? it.imm :
								(m == OP_PUSH_R) ? vm_regs[it.ra] : it.inval;
							vm_dcount++;
						end
					end
					OP_POP, OP_POP_R: begin
						if (vm_dcount == 0) r.error_code = ERR_UNDERFLOW;
						else begin
							vm_dcount--;
							if (m == OP_POP_R) vm_regs[it.ra] = vm_dstack[vm_dcount];
						end
					end
					OP_OUT: begin
						if (vm_dcount == 0) r.error_code = ERR_UNDERFLOW;
						else begin
							r.out_valid = 1'b1;
							r.out_value = vm_dstack[vm_dcount - 1];
						end
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
						if (vm_dcount < 2) r.error_code = ERR_UNDERFLOW;
						else begin
							b = vm_dstack[vm_dcount - 1];
							a = vm_dstack[vm_dcount - 2];
							if (m == OP_DIV && b == 0) r.error_code = ERR_DIV_ZERO;
							else begin
								vm_dcount--;
								vm_dstack[vm_dcount - 1] = fx_arith(m, a, b);
							end
						end
					end
					OP_ADD_R, OP_SUB_R, OP_MUL_R, OP_DIV_R: begin
						a = vm_regs[it.rb];
						b = vm_regs[it.rc];
						if (m == OP_DIV_R && b == 0) r.error_code = ERR_DIV_ZERO;
						else vm_regs[it.ra] = fx_arith(m, a, b);
					end
					OP_INC: vm_regs[it.ra] = clamp32(longint'(vm_regs[it.ra]) + 65536);
					OP_DEC: vm_regs[it.ra] = clamp32(longint'(vm_regs[it.ra]) - 65536);
					OP_MOV_C: vm_regs[it.ra] = it.imm;
					OP_MOV_R: vm_regs[it.ra] = vm_regs[it.rb];
					OP_JMP: jump = 1'b1;
					OP_JE:  jump = (vm_regs[it.ra] == 0);
					OP_JNE: jump = (vm_regs[it.ra] != 0);
					OP_JL:  jump = (vm_regs[it.ra] < vm_regs[it.rb]);
					OP_JG:  jump = (vm_regs[it.ra] > vm_regs[it.rb]);
					OP_CALL: begin
						if (vm_rcount >= 16) r.error_code = ERR_CALL;
						else begin
							vm_rstack[vm_rcount] = 12'(raw % 4096);
							vm_rcount++;
							jump = 1'b1;
						end
					end
					OP_RET: begin
						if (vm_rcount == 0) r.error_code = ERR_CALL;
						else begin
							vm_rcount--;
							tgt = vm_rstack[vm_rcount];
							jump = 1'b1;
						end
					end
					OP_END: vm_stopped = 1'b1;
					default: r.error_code = ERR_BAD_OP;
				endcase
			end
			if (!vm_stopped) begin
				if (jump) raw = tgt;
				if (raw >= lim) vm_stopped = 1'b1;
				vm_pc = raw % 4096;
			end
		end
		r.next_pc = vm_pc[11:0];
		r.halted = vm_stopped;
		return r;
	endfunction

	function automatic logic [31:0] rand_fixed();
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = SAT_MAX;
			1: v = SAT_MIN;
			2: v = 32'd0;
			3: v = {{16{1'b0}}, 16'($urandom_range(0, 8))} << 16;
			4: v = -($urandom_range(0, 8) << 16);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] rand_reg();
		return ($urandom_range(99) < 5) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
	endfunction

	// a random instruction that keeps the program running inside its length
	function automatic instr_t next_random_instr();
		instr_t it;
		int unsigned lim, pick;
		lim = (vm_len > 4096) ? 4096 : vm_len;
		it.ra = rand_reg();
		it.rb = rand_reg();
		it.rc = rand_reg();
		it.imm = rand_fixed();
		it.inval = rand_fixed();
		it.tgt = 12'($urandom_range(0, lim - 1));
		pick = $urandom_range(99);
		if (pick < 7) begin
			case ($urandom_range(2))
				0: it.mode = 5'd0;
				1: it.mode = OP_LABEL;
				default: it.mode = 5'($urandom_range(28, 31));
			endcase
			it.tgt = 12'($urandom);
		end else if (pick < 20) begin
			it.mode = (pick < 14) ? OP_PUSH_C : OP_IN;
		end else begin
			it.mode = 5'($urandom_range(OP_PUSH_C, OP_RET));
		end
		if (it.mode == OP_RET && vm_rcount > 0 && vm_rstack[vm_rcount - 1] + 10 >= lim)
			it.mode = OP_JMP;
		if (vm_pc + 10 >= lim) begin
			it.mode = OP_JMP;
			it.tgt = 12'($urandom_range(0, lim / 2));
		end
		return it;
	endfunction

	task automatic send_instr(input instr_t it, input bit typed, input outcome_t typed_res);
		outcome_t res;
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		reg_a <= it.ra;
		reg_b <= it.rb;
		reg_c <= it.rc;
		immediate <= it.imm;
		jump_target <= it.tgt;
		in_value <= it.inval;
		do @(posedge clk); while (!in_ready);
		res = execute_instr(it);
		pending_q.push_back(typed ? typed_res : res);
		n_items++;
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) send_instr(next_random_instr(), 1'b0, '0);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_length(input logic [12:0] v);
		instr_t j;
		// bring the counter home first so a shorter length does not stop the core
		j = '0;
		j.mode = OP_JMP;
		if (vm_len != 0) send_instr(j, 1'b0, '0);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vm_len = v;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
			$display("** stack_vm_instruction_execute: FAILED **");
			$finish;
		end
	end

	// result side: random stalls plus a long hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= 300;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && res_valid && res_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result transaction with nothing expected, next_pc %h", $time, next_pc);
				fail_count++;
			end else begin
				e = pending_q.pop_front();
				check_field("next_pc", e.next_pc, next_pc);
				check_field("out_valid", e.out_valid, out_valid);
				check_field("out_value", e.out_value, out_value);
				check_field("halted", e.halted, halted);
				check_field("error_code", e.error_code, error_code);
				n_results++;
				if (out_valid) n_outs++;
				if (error_code != ERR_NONE) n_errs++;
			end
		end
	end

	initial begin
		instr_t ins;
		outcome_t tr;
		int unsigned i;
		for (i = 0; i < 5; i++) vm_regs[i] = 0;
		vm_dcount = 0;
		vm_rcount = 0;
		vm_pc = 0;
		vm_stopped = 1'b0;
		vm_len = 0;
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= '0;
		reg_a <= '0;
		reg_b <= '0;
		reg_c <= '0;
		immediate <= '0;
		jump_target <= '0;
		in_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_length(13'h1FFF);
		for (i = 0; i < 26; i++) begin
			tr = '0;
			tr.next_pc = dir_rows[i].epc;
			tr.error_code = dir_rows[i].eerr;
			send_instr(dir_rows[i].ins, dir_rows[i].typed, tr);
		end

		send_random(PHASE_ITEMS);
		write_length(13'd4096);
		gap_pct = 61;
		send_random(PHASE_ITEMS);
		write_length(13'd2000);
		gap_pct = 0;
		stall_pct = 61;
		hold_reqs++;
		send_random(PHASE_ITEMS / 2);
		drain_results();
		send_random(PHASE_ITEMS / 2);
		write_length(13'd4097);
		gap_pct = 24;
		stall_pct = 24;
		send_random(PHASE_ITEMS);
		write_length(13'd300);
		gap_pct = 0;
		stall_pct = 0;
		send_random(PHASE_ITEMS);

		// end opcode stops the core for good; later instructions only report halt
		ins = '0;
		ins.mode = OP_END;
		send_instr(ins, 1'b0, '0);
		send_random(3);
		write_length(13'd0);
		send_random(3);
		drain_results();
		repeat (20) @(posedge clk);

		$display("run: %0d instructions, %0d results, %0d out values, %0d error results",
			n_items, n_results, n_outs, n_errs);
		$display("covered lengths from 0 to 8191, sender gaps, result stalls and a long hold-off");
		if (fail_count == 0 && pending_q.size() == 0) begin
			$display("** stack_vm_instruction_execute: PASSED **");
		end else begin
			$display("** stack_vm_instruction_execute: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
